### hw/rtl/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// types, constants and character tables of the request header parser
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int PATH_LIMIT  = 64;
    localparam int QUERY_LIMIT = 128;
    localparam int BODY_LIMIT  = 1024;

    localparam int PATH_W  = $clog2(PATH_LIMIT);
    localparam int QUERY_W = $clog2(QUERY_LIMIT);
    localparam int LEN_W   = 11;
    localparam int ACC_W   = LEN_W + 4;

    localparam logic [PATH_W-1:0]  PATH_CNT_MAX  = PATH_W'(PATH_LIMIT - 1);
    localparam logic [QUERY_W-1:0] QUERY_CNT_MAX = QUERY_W'(QUERY_LIMIT - 1);
    localparam logic [ACC_W-1:0]   BODY_MAX_ACC  = ACC_W'(BODY_LIMIT);

    localparam logic [2:0] KIND_PATH  = 3'd0;
    localparam logic [2:0] KIND_QUERY = 3'd1;
    localparam logic [2:0] KIND_DONE  = 3'd2;
    localparam logic [2:0] KIND_BAD   = 3'd3;
    localparam logic [2:0] KIND_BODY  = 3'd4;

    localparam logic [1:0] CRLF_NONE    = 2'd0;
    localparam logic [1:0] CRLF_CR      = 2'd1;
    localparam logic [1:0] CRLF_CRLF    = 2'd2;
    localparam logic [1:0] CRLF_CRLF_CR = 2'd3;

    localparam logic [1:0] DIG_BEFORE = 2'd0;
    localparam logic [1:0] DIG_POS    = 2'd1;
    localparam logic [1:0] DIG_NEG    = 2'd2;
    localparam logic [1:0] DIG_ENDED  = 2'd3;

    localparam logic [3:0] CLEN_LEN = 4'd15;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_request;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       value;
        logic             method;
        logic [LEN_W-1:0] body_length;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] low_byte;
        logic       start;
        logic       is_cr;
        logic       is_lf;
        logic       is_sp;
        logic       is_qm;
        logic       is_digit;
        logic       is_ws;
        logic       is_plus;
        logic       is_minus;
    } t_cls_item;

    function automatic logic [7:0] get_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "G";
            4'd1:    c = "E";
            4'd2:    c = "T";
            4'd3:    c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] post_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "P";
            4'd1:    c = "O";
            4'd2:    c = "S";
            4'd3:    c = "T";
            4'd4:    c = " ";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] clen_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/hrp_front.sv
// ----------------------------------------------------------------------------
// hrp_front
// accepts request bytes, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module hrp_front
    import hrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    input  logic      i_take,
    output logic      o_valid,
    output t_cls_item o_cls
);

    t_cls_item  r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    t_cls_item  w_cls;
    logic       w_push;
    logic       w_pop;
    logic [7:0] w_b;

    assign w_b = i_item.data_byte;

    always_comb begin
        w_cls.data_byte = w_b;
        w_cls.low_byte  = (w_b >= "A" && w_b <= "Z") ? w_b + 8'd32 : w_b;
        w_cls.start     = i_item.start_request;
        w_cls.is_cr     = (w_b == 8'h0d);
        w_cls.is_lf     = (w_b == 8'h0a);
        w_cls.is_sp     = (w_b == " ");
        w_cls.is_qm     = (w_b == "?");
        w_cls.is_digit  = (w_b >= "0" && w_b <= "9");
        w_cls.is_ws     = (w_b == " ") || (w_b == 8'h09) || (w_b == 8'h0a) ||
                          (w_b == 8'h0b) || (w_b == 8'h0c);
        w_cls.is_plus   = (w_b == "+");
        w_cls.is_minus  = (w_b == "-");
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cls   = r_mem[r_rp];
    assign w_push  = push && !full;
    assign w_pop   = o_valid && i_take;

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cls;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("front queue count out of range");

endmodule

### hw/rtl/hrp_back.sv
// ----------------------------------------------------------------------------
// hrp_back
// request parser state machine with a two-entry result queue
// ----------------------------------------------------------------------------
module hrp_back
    import hrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cls_item i_cls,
    output logic      o_take,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    typedef enum logic [8:0] {
        PH_METHOD    = 9'b000000001,
        PH_PATH      = 9'b000000010,
        PH_QUERY     = 9'b000000100,
        PH_LINE_REST = 9'b000001000,
        PH_HDR_NAME  = 9'b000010000,
        PH_HDR_VALUE = 9'b000100000,
        PH_HDR_SKIP  = 9'b001000000,
        PH_BODY      = 9'b010000000,
        PH_IDLE      = 9'b100000000
    } t_phase;

    t_phase             r_phase, n_phase, c_phase;
    logic [3:0]         r_pos, n_pos, c_pos;
    logic               r_meth, n_meth, c_meth;
    logic               r_lerr, n_lerr, c_lerr;
    logic [PATH_W-1:0]  r_pcnt, n_pcnt, c_pcnt;
    logic [QUERY_W-1:0] r_qcnt, n_qcnt, c_qcnt;
    logic [1:0]         r_crlf, n_crlf, c_crlf;
    logic [LEN_W-1:0]   r_len, n_len, c_len;
    logic [1:0]         r_dig, n_dig, c_dig;
    logic [LEN_W-1:0]   r_bcnt, n_bcnt, c_bcnt;

    t_out_item  r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic       w_emit;
    t_out_item  w_res;
    logic       w_take;
    logic       w_push;
    logic       w_pop;
    logic [7:0] w_b;
    logic [7:0] w_want;
    logic [3:0] w_mlen;
    logic [ACC_W-1:0] w_acc;

    assign w_b    = i_cls.data_byte;
    assign o_take = i_valid && (r_cnt != 2'd2);
    assign w_take = o_take;
    assign w_push = w_take && w_emit;
    assign empty  = (r_cnt == 2'd0);
    assign o_item = r_mem[r_rp];
    assign w_pop  = pop && !empty;

    always_comb begin
        if (i_cls.start) begin
            c_phase = PH_METHOD;
            c_pos   = 4'd0;
            c_meth  = 1'b0;
            c_lerr  = 1'b0;
            c_pcnt  = '0;
            c_qcnt  = '0;
            c_crlf  = CRLF_NONE;
            c_len   = '0;
            c_dig   = DIG_BEFORE;
            c_bcnt  = '0;
        end else begin
            c_phase = r_phase;
            c_pos   = r_pos;
            c_meth  = r_meth;
            c_lerr  = r_lerr;
            c_pcnt  = r_pcnt;
            c_qcnt  = r_qcnt;
            c_crlf  = r_crlf;
            c_len   = r_len;
            c_dig   = r_dig;
            c_bcnt  = r_bcnt;
        end
    end

    always_comb begin
        w_mlen = c_meth ? 4'd5 : 4'd4;
        w_want = c_meth ? post_char(c_pos) : get_char(c_pos);
        w_acc  = ({4'b0, c_len} << 3) + ({4'b0, c_len} << 1) + {11'b0, w_b[3:0]};
    end

    always_comb begin
        n_phase = c_phase;
        n_pos   = c_pos;
        n_meth  = c_meth;
        n_lerr  = c_lerr;
        n_pcnt  = c_pcnt;
        n_qcnt  = c_qcnt;
        n_crlf  = c_crlf;
        n_len   = c_len;
        n_dig   = c_dig;
        n_bcnt  = c_bcnt;
        w_emit  = 1'b0;
        w_res   = '0;
        if (c_phase == PH_IDLE) begin
            w_emit = 1'b0;
        end else if (c_phase == PH_BODY) begin
            n_bcnt        = c_bcnt + 1'b1;
            w_emit        = 1'b1;
            w_res.kind    = KIND_BODY;
            w_res.value   = w_b;
            w_res.last    = (n_bcnt >= c_len);
            if (n_bcnt >= c_len) begin
                n_phase = PH_IDLE;
            end
        end else if (i_cls.is_cr) begin
            if (c_phase inside {PH_METHOD, PH_PATH, PH_QUERY}) begin
                n_lerr  = 1'b1;
                n_phase = PH_LINE_REST;
            end else if (c_phase == PH_HDR_NAME) begin
                n_phase = PH_HDR_SKIP;
            end else if (c_phase == PH_HDR_VALUE) begin
                n_dig = DIG_ENDED;
            end
            n_crlf = (c_crlf == CRLF_CRLF) ? CRLF_CRLF_CR : CRLF_CR;
        end else if (i_cls.is_lf && c_crlf == CRLF_CRLF_CR) begin
            n_crlf = CRLF_NONE;
            w_emit = 1'b1;
            if (c_lerr) begin
                n_phase    = PH_IDLE;
                w_res.kind = KIND_BAD;
                w_res.last = 1'b1;
            end else begin
                n_phase           = (c_len == '0) ? PH_IDLE : PH_BODY;
                n_bcnt            = '0;
                w_res.kind        = KIND_DONE;
                w_res.method      = c_meth;
                w_res.body_length = c_len;
                w_res.last        = (c_len == '0);
            end
        end else if (i_cls.is_lf && c_crlf == CRLF_CR) begin
            n_crlf  = CRLF_CRLF;
            n_phase = PH_HDR_NAME;
            n_pos   = 4'd0;
        end else begin
            n_crlf = CRLF_NONE;
            unique case (c_phase)
                PH_METHOD: begin
                    if (c_pos == 4'd0) begin
                        if (w_b == "G" || w_b == "P") begin
                            n_meth = (w_b == "P");
                            n_pos  = 4'd1;
                        end else begin
                            n_lerr  = 1'b1;
                            n_phase = PH_LINE_REST;
                        end
                    end else if (c_pos < w_mlen && w_b == w_want) begin
                        n_pos = c_pos + 4'd1;
                        if (c_pos + 4'd1 == w_mlen) begin
                            n_phase = PH_PATH;
                            n_pos   = 4'd0;
                        end
                    end else begin
                        n_lerr  = 1'b1;
                        n_phase = PH_LINE_REST;
                    end
                end
                PH_PATH: begin
                    if (i_cls.is_sp) begin
                        n_phase = PH_LINE_REST;
                    end else if (i_cls.is_qm) begin
                        n_phase = PH_QUERY;
                    end else if (c_pcnt < PATH_CNT_MAX) begin
                        n_pcnt      = c_pcnt + 1'b1;
                        w_emit      = 1'b1;
                        w_res.kind  = KIND_PATH;
                        w_res.value = w_b;
                    end
                end
                PH_QUERY: begin
                    if (i_cls.is_sp) begin
                        n_phase = PH_LINE_REST;
                    end else if (c_qcnt < QUERY_CNT_MAX) begin
                        n_qcnt      = c_qcnt + 1'b1;
                        w_emit      = 1'b1;
                        w_res.kind  = KIND_QUERY;
                        w_res.value = w_b;
                    end
                end
                PH_HDR_NAME: begin
                    if (c_pos < CLEN_LEN && i_cls.low_byte == clen_char(c_pos)) begin
                        n_pos = c_pos + 4'd1;
                        if (c_pos + 4'd1 == CLEN_LEN) begin
                            n_phase = PH_HDR_VALUE;
                            n_len   = '0;
                            n_dig   = DIG_BEFORE;
                        end
                    end else begin
                        n_phase = PH_HDR_SKIP;
                    end
                end
                PH_HDR_VALUE: begin
                    if (c_dig == DIG_BEFORE) begin
                        if (i_cls.is_ws) begin
                            n_dig = DIG_BEFORE;
                        end else if (i_cls.is_plus) begin
                            n_dig = DIG_POS;
                        end else if (i_cls.is_minus) begin
                            n_dig = DIG_NEG;
                        end else if (!i_cls.is_digit) begin
                            n_dig = DIG_ENDED;
                        end else begin
                            n_dig = DIG_POS;
                            n_len = (w_acc > BODY_MAX_ACC) ? LEN_W'(BODY_LIMIT)
                                                           : w_acc[LEN_W-1:0];
                        end
                    end else if (!i_cls.is_digit) begin
                        n_dig = DIG_ENDED;
                    end else if (c_dig == DIG_POS) begin
                        n_len = (w_acc > BODY_MAX_ACC) ? LEN_W'(BODY_LIMIT)
                                                       : w_acc[LEN_W-1:0];
                    end
                end
                PH_LINE_REST, PH_HDR_SKIP, PH_BODY, PH_IDLE: begin
                    n_phase = c_phase;
                end
                default: begin
                    n_phase = c_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD;
            r_pos   <= 4'd0;
            r_meth  <= 1'b0;
            r_lerr  <= 1'b0;
            r_pcnt  <= '0;
            r_qcnt  <= '0;
            r_crlf  <= CRLF_NONE;
            r_len   <= '0;
            r_dig   <= DIG_BEFORE;
            r_bcnt  <= '0;
        end else if (w_take) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_meth  <= n_meth;
            r_lerr  <= n_lerr;
            r_pcnt  <= n_pcnt;
            r_qcnt  <= n_qcnt;
            r_crlf  <= n_crlf;
            r_len   <= n_len;
            r_dig   <= n_dig;
            r_bcnt  <= n_bcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= w_push ? ~r_wp : r_wp;
            r_rp  <= w_pop ? ~r_rp : r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_res;
        end
    end

    a_res_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && r_cnt == 2'd2))
        else $error("result pushed into full queue");

    a_done_to_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_res.kind == KIND_DONE && !w_res.last) |=> (r_phase == PH_BODY))
        else $error("headers done with length did not enter body");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_res.last) |=> (r_phase == PH_IDLE))
        else $error("last item did not end the request");

endmodule

### hw/rtl/http_request_header_parser.sv
// ----------------------------------------------------------------------------
// http_request_header_parser
// request line, path, query and content-length parser with body passthrough
// ----------------------------------------------------------------------------
// an accepted byte waits in the input queue, then is parsed and its result registered in the result queue
// throughput: one byte per cycle while the result queue is not full
// two-entry queues sit between input, parser and result ports
// reset: synchronous active low, empties both queues, parser to method match
// ----------------------------------------------------------------------------
module http_request_header_parser
    import hrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    logic      w_valid;
    logic      w_take;
    t_cls_item w_cls;

    hrp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .i_take  (w_take),
        .o_valid (w_valid),
        .o_cls   (w_cls)
    );

    hrp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_cls   (w_cls),
        .o_take  (w_take),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

endmodule
